[sv/pqs_pkg.sv]
// Types, constants and codes shared by the priority queue store modules.
package pqs_pkg;

   // Default depth of the cell chain
   localparam int PQS_DEPTH = 16;
   localparam int DATA_W = 32;
   localparam int OCC_W = 5;

   // Operation codes
   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_REMOVE = 1'b1
   } cmd_type;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // One request transaction
   typedef struct packed {
      cmd_type                  cmd;
      logic signed [DATA_W-1:0] entry_value;
      logic signed [DATA_W-1:0] entry_priority;
   } req_type;

   // One response transaction
   typedef struct packed {
      logic signed [DATA_W-1:0] out_value;
      logic signed [DATA_W-1:0] out_priority;
      logic                     out_valid;
      status_type               status;
      logic [OCC_W-1:0]         occupancy;
   } rsp_type;

   // Contents of one slot
   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] prio;
   } entry_type;

   // Command broadcast to every cell
   typedef struct packed {
      logic      insert;
      logic      remove;
      entry_type new_entry;
   } cell_ctl_type;

endpackage

[sv/pqs_cell.sv]
// One slot of the sorted chain: holds an entry, shifts down on insert, up on remove.
module pqs_cell (
   input  logic                  clock,
   input  pqs_pkg::cell_ctl_type ctl,
   input  logic                  occupied,
   input  pqs_pkg::entry_type    above_entry,
   input  logic                  above_ge,
   input  pqs_pkg::entry_type    below_entry,
   output pqs_pkg::entry_type    entry,
   output logic                  ge
);

   pqs_pkg::entry_type entry_ff;
   pqs_pkg::entry_type entry_in;

   // New entry belongs here or above: slot free, or new priority not below ours
   assign ge = !occupied || (ctl.new_entry.prio >= entry_ff.prio);

   // Slot update: take the new entry at the boundary, shift down below it,
   // shift up on remove
   always_comb begin
      entry_in = entry_ff;
      if (ctl.insert) begin
         if (above_ge) begin
            entry_in = above_entry;
         end else if (ge) begin
            entry_in = ctl.new_entry;
         end
      end else if (ctl.remove) begin
         entry_in = below_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

[sv/priority_queue_store_core.sv]
// Top level of the priority queue store: control, count and a chain of sorted cells.
// A result appears in the cycle after its transaction is accepted.
// Throughput: one insert or remove per cycle; all cells compare and shift in the same cycle.
// busy stays low, so start is taken at every edge; the receiver cannot stall.
// Reset clears the entry count and the response strobe; slot contents are not cleared.
module priority_queue_store_core #(
   parameter int DEPTH = pqs_pkg::PQS_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  pqs_pkg::req_type req_data,
   output logic             rsp_strobe,
   output pqs_pkg::rsp_type rsp_data
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic                  rsp_strobe_ff;
   pqs_pkg::rsp_type      rsp_ff;
   pqs_pkg::rsp_type      rsp_in;
   logic                  accept;
   logic                  full;
   logic                  empty;
   logic                  do_ins;
   logic                  do_rem;
   pqs_pkg::cell_ctl_type ctl;
   pqs_pkg::entry_type    cell_entry [DEPTH];
   logic                  cell_ge [DEPTH];
   logic                  cell_occ [DEPTH];

   // Command decode
   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign full   = (count_ff == CNT_W'(DEPTH));
   assign empty  = (count_ff == '0);
   assign do_ins = accept && (req_data.cmd == pqs_pkg::CMD_INSERT) && !full;
   assign do_rem = accept && (req_data.cmd == pqs_pkg::CMD_REMOVE) && !empty;

   assign ctl.insert          = do_ins;
   assign ctl.remove          = do_rem;
   assign ctl.new_entry.value = req_data.entry_value;
   assign ctl.new_entry.prio  = req_data.entry_priority;

   // Cell chain, slot 0 holds the highest priority
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign cell_occ[i] = (CNT_W'(i) < count_ff);
      if (i == 0) begin : g_head
         pqs_cell u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .occupied    (cell_occ[i]),
            .above_entry (ctl.new_entry),
            .above_ge    (1'b0),
            .below_entry (cell_entry[i+1]),
            .entry       (cell_entry[i]),
            .ge          (cell_ge[i])
         );
      end else if (i == DEPTH - 1) begin : g_tail
         pqs_cell u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .occupied    (cell_occ[i]),
            .above_entry (cell_entry[i-1]),
            .above_ge    (cell_ge[i-1]),
            .below_entry (cell_entry[i]),
            .entry       (cell_entry[i]),
            .ge          (cell_ge[i])
         );
      end else begin : g_mid
         pqs_cell u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .occupied    (cell_occ[i]),
            .above_entry (cell_entry[i-1]),
            .above_ge    (cell_ge[i-1]),
            .below_entry (cell_entry[i+1]),
            .entry       (cell_entry[i]),
            .ge          (cell_ge[i])
         );
      end
   end

   // Count and response next values
   always_comb begin
      count_in = count_ff;
      if (do_ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rem) begin
         count_in = count_ff - CNT_W'(1);
      end
      rsp_in              = '0;
      rsp_in.status       = pqs_pkg::STATUS_OK;
      if (do_rem) begin
         rsp_in.out_value    = cell_entry[0].value;
         rsp_in.out_priority = cell_entry[0].prio;
         rsp_in.out_valid    = 1'b1;
      end else if (accept && (req_data.cmd == pqs_pkg::CMD_INSERT) && full) begin
         rsp_in.status = pqs_pkg::STATUS_FULL;
      end else if (accept && (req_data.cmd == pqs_pkg::CMD_REMOVE) && empty) begin
         rsp_in.status = pqs_pkg::STATUS_EMPTY;
      end
      rsp_in.occupancy = pqs_pkg::OCC_W'(count_in);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= accept;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_strobe_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe_ff)
      else $error("accepted transaction gave no response");

   a_strobe_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(accept))
      else $error("response without a transaction");

   a_valid_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_ff.out_valid) |-> (rsp_ff.status == pqs_pkg::STATUS_OK))
      else $error("removed entry with error status");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CNT_W'(2)) |-> (cell_entry[0].prio >= cell_entry[1].prio))
      else $error("head cells out of order");

   a_remove_count: assert property (@(posedge clock) disable iff (reset)
      do_rem |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("remove did not decrement count");
`endif

endmodule
